>>> rtl/bti_pkg.sv
// shared types and constants of the breakpoint table interpolator
// no dependencies; used by breakpoint_table_interpolator_top
package bti_pkg;

	// request kind carried on the input tuser
	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	localparam int TIME_W   = 32;
	localparam int VALUE_W  = 16;
	localparam int INDEX_W  = 6;
	localparam int COUNT_W  = 7;
	localparam int RESULT_W = 33;
	localparam int SUM_W    = 42;

	// input tdata field offsets, lowest bit first
	localparam int IDX_LO   = 0;
	localparam int ETIME_LO = IDX_LO + INDEX_W;
	localparam int EVAL_LO  = ETIME_LO + TIME_W;
	localparam int QTIME_LO = EVAL_LO + VALUE_W;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 40;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd2;

	// half of one integer step in q16.16
	localparam logic signed [SUM_W-1:0] HALF_Q = 42'sd32768;
	localparam logic signed [SUM_W-1:0] OUT_MAX = 42'sd2147450880;
	localparam logic signed [SUM_W-1:0] OUT_MIN = -42'sd2147516416;
	// offset used once the integer quotient passes 2^24
	localparam logic signed [SUM_W-1:0] DELTA_LIM = 42'sd1099511627776;

endpackage

>>> rtl/breakpoint_table_interpolator_top.sv
// top level of the breakpoint table interpolator: table memory, search and arithmetic sequencer
// depends on bti_pkg
//
// Piecewise linear lookup over a table of (time, value) breakpoints. A write request
// (tuser = 0) stores one entry. A query request (tuser = 1) picks the segment by binary
// search over the first point_count entries, then interpolates with one 32x16 multiply
// and a radix-2 restoring divider that yields one quotient bit per cycle over its 64
// steps. Each search step issues a probe read in S_SRCH and compares it in S_CMP,
// because the table memory has a registered read. A query outside the table skips the
// search, and an equal-time segment skips the divider. The block accepts no request
// while a query is in flight; a finished result sits in an output register, so the next
// request may enter while the previous result still waits on the master side, and a
// query that finishes while that register is still full waits in its last step. Queries
// outside the table extend the end segment, clamped to half a step beyond the nearer
// endpoint value, and equal segment times give value zero with the degenerate flag set.
// Table entries that were never written read back as undefined. There is no clearing
// pass after reset.
module breakpoint_table_interpolator_top #(
	parameter int MAX_POINTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration: point_count
	input  logic                                cfg_we,
	input  logic [bti_pkg::COUNT_W-1:0]         cfg_wdata,
	// request side
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// entry_index[5:0], entry_time[37:6], entry_value[53:38], query_time[85:54], zero pad
	input  logic [bti_pkg::IN_DATA_W-1:0]       s_tdata,
	// action[0]
	input  logic                                s_tuser,
	// result side
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// interpolated_value[32:0], zero pad
	output logic [bti_pkg::OUT_DATA_W-1:0]      m_tdata,
	// degenerate[0]
	output logic                                m_tuser
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	// wide enough for the 7-bit count, the 6-bit index and MAX_POINTS itself
	localparam int XW = ((AW > bti_pkg::COUNT_W) ? AW : bti_pkg::COUNT_W) + 1;
	localparam int XCW = (CW > XW) ? CW : XW;
	localparam int ENTRY_W = bti_pkg::TIME_W + bti_pkg::VALUE_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIRST,
		S_LAST,
		S_CHK,
		S_SRCH,
		S_CMP,
		S_P1,
		S_P2,
		S_DIFF,
		S_MUL,
		S_DIV,
		S_ADD,
		S_CLAMP,
		S_OUT
	} state_t;

	state_t state_q;

	// table memory: time in the upper bits, value in the lower bits
	logic [ENTRY_W-1:0] mem [MAX_POINTS];
	logic [ENTRY_W-1:0] rd_q;
	logic [AW-1:0]      rd_addr;

	logic [bti_pkg::COUNT_W-1:0] point_count_q;

	// request fields
	logic        req_acc;
	logic [bti_pkg::INDEX_W-1:0] entry_index;
	logic signed [bti_pkg::TIME_W-1:0]  entry_time;
	logic signed [bti_pkg::VALUE_W-1:0] entry_value;
	logic signed [bti_pkg::TIME_W-1:0]  query_time;
	logic [XW-1:0] idx_x;
	logic          wr_en;
	logic [XCW-1:0] cnt_x;
	logic [CW-1:0]  n_sat;

	// query working registers
	logic signed [bti_pkg::TIME_W-1:0]  t_q;
	logic [CW-1:0]  n_q;
	logic [AW-1:0]  a_q;
	logic [AW-1:0]  b_q;
	logic           lt0_q;
	logic signed [bti_pkg::TIME_W-1:0]  x1_q;
	logic signed [bti_pkg::TIME_W-1:0]  x2_q;
	logic signed [bti_pkg::VALUE_W-1:0] y1_q;
	logic signed [bti_pkg::VALUE_W-1:0] y2_q;
	logic signed [bti_pkg::TIME_W:0]    d_q;
	logic signed [bti_pkg::TIME_W:0]    dx_q;
	logic signed [bti_pkg::VALUE_W:0]   dy_q;
	logic        neg_q;
	logic [31:0] dmag_q;
	logic [63:0] div_q;
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;
	logic signed [bti_pkg::SUM_W-1:0] r_q;
	logic        degen_q;

	// output register
	logic        out_valid_q;
	logic [bti_pkg::RESULT_W-1:0] out_data_q;
	logic        out_degen_q;

	// read data views
	logic signed [bti_pkg::TIME_W-1:0]  rd_time;
	logic signed [bti_pkg::VALUE_W-1:0] rd_value;

	// search helpers
	logic [AW:0]   mid_sum;
	logic [AW-1:0] mid;
	logic [AW-1:0] n_m1;
	logic [AW-1:0] n_m2;

	// multiplier and divider datapath
	logic [bti_pkg::TIME_W:0]  d_abs;
	logic [bti_pkg::TIME_W:0]  dx_abs;
	logic [bti_pkg::VALUE_W:0] dy_abs;
	logic [47:0] prod;
	logic [32:0] trial;
	logic        trial_ge;
	logic [32:0] trial_sub;

	// final add, clamp and saturation
	logic        q_sat;
	logic signed [bti_pkg::SUM_W-1:0] q_ext;
	logic signed [bti_pkg::SUM_W-1:0] delta;
	logic signed [bti_pkg::SUM_W-1:0] y1_ext;
	logic signed [bti_pkg::SUM_W-1:0] y2_ext;
	logic signed [bti_pkg::SUM_W-1:0] r_clamp;
	logic signed [bti_pkg::SUM_W-1:0] r_sat;

	assign entry_index = s_tdata[bti_pkg::IDX_LO +: bti_pkg::INDEX_W];
	assign entry_time  = $signed(s_tdata[bti_pkg::ETIME_LO +: bti_pkg::TIME_W]);
	assign entry_value = $signed(s_tdata[bti_pkg::EVAL_LO +: bti_pkg::VALUE_W]);
	assign query_time  = $signed(s_tdata[bti_pkg::QTIME_LO +: bti_pkg::TIME_W]);

	assign s_tready = (state_q == S_IDLE);
	assign req_acc  = s_tvalid && s_tready;

	// writes beyond the table are dropped
	assign idx_x = XW'(entry_index);
	assign wr_en = req_acc && (s_tuser == bti_pkg::ACT_WRITE) && (idx_x < XW'(MAX_POINTS));

	// point_count saturated to 2..MAX_POINTS
	assign cnt_x = XCW'(point_count_q);
	always_comb begin
		if (cnt_x < XCW'(2)) begin
			n_sat = CW'(2);
		end else if (cnt_x > XCW'(MAX_POINTS)) begin
			n_sat = CW'(MAX_POINTS);
		end else begin
			n_sat = CW'(cnt_x);
		end
	end

	assign rd_time  = $signed(rd_q[ENTRY_W-1 -: bti_pkg::TIME_W]);
	assign rd_value = $signed(rd_q[bti_pkg::VALUE_W-1:0]);

	assign mid_sum = {1'b0, a_q} + {1'b0, b_q};
	assign mid     = mid_sum[AW:1];
	assign n_m1    = AW'(n_q - CW'(1));
	assign n_m2    = AW'(n_q - CW'(2));

	// memory read address by sequencer step
	always_comb begin
		unique case (state_q)
			S_LAST:  rd_addr = n_m1;
			S_SRCH:  rd_addr = mid;
			S_CMP:   rd_addr = mid;
			S_P1:    rd_addr = a_q;
			S_P2:    rd_addr = a_q + AW'(1);
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_x[AW-1:0]] <= {entry_time, entry_value};
		end
		rd_q <= mem[rd_addr];
	end

	// magnitudes for the unsigned multiply and divide
	assign d_abs  = d_q[bti_pkg::TIME_W]  ? -d_q  : d_q;
	assign dx_abs = dx_q[bti_pkg::TIME_W] ? -dx_q : dx_q;
	assign dy_abs = dy_q[bti_pkg::VALUE_W] ? -dy_q : dy_q;
	assign prod   = d_abs[31:0] * dy_abs[15:0];

	// one restoring division step
	assign trial     = {rem_q, div_q[63]};
	assign trial_ge  = (trial >= {1'b0, dmag_q});
	assign trial_sub = trial - {1'b0, dmag_q};

	// integer part of the quotient above 2^24 saturates the offset
	assign q_sat  = (|div_q[63:41]) || (div_q[40] && (|div_q[39:16]));
	assign q_ext  = $signed({1'b0, div_q[40:0]});
	assign y1_ext = bti_pkg::SUM_W'(y1_q) <<< 16;
	assign y2_ext = bti_pkg::SUM_W'(y2_q) <<< 16;

	always_comb begin
		if (q_sat) begin
			delta = neg_q ? -bti_pkg::DELTA_LIM : bti_pkg::DELTA_LIM;
		end else begin
			delta = neg_q ? -q_ext : q_ext;
		end
	end

	// extension clamp, half a step past the nearer endpoint along the slope
	always_comb begin
		r_clamp = r_q;
		priority if (t_q > x2_q) begin
			if (y2_q > y1_q) begin
				if (r_q > y2_ext + bti_pkg::HALF_Q) r_clamp = y2_ext + bti_pkg::HALF_Q;
			end else begin
				if (r_q < y2_ext - bti_pkg::HALF_Q) r_clamp = y2_ext - bti_pkg::HALF_Q;
			end
		end else if (t_q < x1_q) begin
			if (y1_q > y2_q) begin
				if (r_q > y1_ext + bti_pkg::HALF_Q) r_clamp = y1_ext + bti_pkg::HALF_Q;
			end else begin
				if (r_q < y1_ext - bti_pkg::HALF_Q) r_clamp = y1_ext - bti_pkg::HALF_Q;
			end
		end else begin
			r_clamp = r_q;
		end
	end

	// output range saturation
	always_comb begin
		priority if (r_q > bti_pkg::OUT_MAX) begin
			r_sat = bti_pkg::OUT_MAX;
		end else if (r_q < bti_pkg::OUT_MIN) begin
			r_sat = bti_pkg::OUT_MIN;
		end else begin
			r_sat = r_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			point_count_q <= bti_pkg::COUNT_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				point_count_q <= cfg_wdata;
			end
			// in S_OUT a new result replaces the one taken in the same cycle
			if (out_valid_q && m_tready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc && (s_tuser == bti_pkg::ACT_QUERY)) begin
						t_q     <= query_time;
						n_q     <= n_sat;
						degen_q <= 1'b0;
						state_q <= S_FIRST;
					end
				end
				// entry 0 read is in flight
				S_FIRST: begin
					state_q <= S_LAST;
				end
				S_LAST: begin
					lt0_q   <= (t_q < rd_time);
					state_q <= S_CHK;
				end
				// rd_q holds the last entry in use
				S_CHK: begin
					if (lt0_q) begin
						a_q     <= '0;
						state_q <= S_P1;
					end else if (t_q > rd_time) begin
						a_q     <= n_m2;
						state_q <= S_P1;
					end else begin
						a_q     <= '0;
						b_q     <= n_m1;
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if ((b_q - a_q) > AW'(1)) begin
						state_q <= S_CMP;
					end else begin
						state_q <= S_P1;
					end
				end
				S_CMP: begin
					if (rd_time > t_q) begin
						b_q <= mid;
					end else begin
						a_q <= mid;
					end
					state_q <= S_SRCH;
				end
				S_P1: begin
					state_q <= S_P2;
				end
				S_P2: begin
					x1_q    <= rd_time;
					y1_q    <= rd_value;
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					x2_q    <= rd_time;
					y2_q    <= rd_value;
					d_q     <= (bti_pkg::TIME_W + 1)'(t_q) - (bti_pkg::TIME_W + 1)'(x1_q);
					dx_q    <= (bti_pkg::TIME_W + 1)'(rd_time) - (bti_pkg::TIME_W + 1)'(x1_q);
					dy_q    <= (bti_pkg::VALUE_W + 1)'(rd_value)
						- (bti_pkg::VALUE_W + 1)'(y1_q);
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (dx_q == '0) begin
						degen_q <= 1'b1;
						r_q     <= '0;
						state_q <= S_OUT;
					end else begin
						neg_q   <= d_q[bti_pkg::TIME_W] ^ dy_q[bti_pkg::VALUE_W]
							^ dx_q[bti_pkg::TIME_W];
						dmag_q  <= dx_abs[31:0];
						div_q   <= {prod, 16'b0};
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= trial_ge ? trial_sub[31:0] : trial[31:0];
					div_q <= {div_q[62:0], trial_ge};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					r_q     <= y1_ext + delta;
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					r_q     <= r_clamp;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= r_sat[bti_pkg::RESULT_W-1:0];
						out_degen_q <= degen_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = bti_pkg::OUT_DATA_W'(out_data_q);
	assign m_tuser  = out_degen_q;

	// a query request always starts the sequencer
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (s_tuser == bti_pkg::ACT_QUERY)) |=> (state_q == S_FIRST))
		else $error("query request did not start the sequencer");

	// the search bracket never collapses while a probe is compared
	a_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (b_q > a_q))
		else $error("search bracket collapsed");

	// the partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < dmag_q))
		else $error("divider remainder out of range");

	// a result is only dropped from the output register once taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(m_tready))
		else $error("result dropped without handshake");

endmodule

>>> tb/interpolation_checker.sv
`timescale 1ns / 1ps
// result checker for breakpoint_table_interpolator_top: mirrors the table and point_count
// from observed traffic, predicts every query answer and compares the result stream; uses bti_pkg
module interpolation_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bti_pkg::COUNT_W-1:0]    cfg_wdata,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [bti_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [bti_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           m_tuser,
	output int                             failures,
	output int                             pending,
	output int                             writes_seen,
	output int                             queries_seen,
	output int                             degenerate_seen,
	output int                             outside_seen
);

	localparam int     MAX_ENTRIES  = 64;
	localparam longint HALF_STEP    = 64'sd32768;
	localparam longint INT_LIMIT    = 64'sd16777216;
	localparam longint OFFSET_LIMIT = 64'sd1099511627776;
	localparam longint VALUE_HI     = 64'sd2147450880;
	localparam longint VALUE_LO     = -64'sd2147516416;

	typedef struct packed {
		logic signed [bti_pkg::RESULT_W-1:0] value;
		logic                                degenerate;
		logic                                outside;
	} answer_t;

	logic signed [bti_pkg::TIME_W-1:0]  bp_time  [MAX_ENTRIES];
	logic signed [bti_pkg::VALUE_W-1:0] bp_value [MAX_ENTRIES];
	logic [bti_pkg::COUNT_W-1:0]        point_count;
	answer_t                            expected_answers [$];

	// segment search plus linear interpolation with clamped extension
	function automatic answer_t interpolate_at(input logic signed [bti_pkg::TIME_W-1:0] qt);
		answer_t ans;
		int      n, lo, hi, mid, seg;
		longint  x, x1, x2, y1, y2, dx, num, quot, rem, offset, r;
		n = int'(point_count);
		if (n < 2) n = 2;
		if (n > MAX_ENTRIES) n = MAX_ENTRIES;
		x = qt;
		ans.outside = 1'b1;
		if (x < bp_time[0]) begin
			seg = 0;
		end else if (x > bp_time[n-1]) begin
			seg = n - 2;
		end else begin
			ans.outside = 1'b0;
			lo = 0;
			hi = n - 1;
			while (hi - lo > 1) begin
				mid = (lo + hi) / 2;
				if (bp_time[mid] > x) hi = mid;
				else lo = mid;
			end
			seg = lo;
		end
		x1 = bp_time[seg];
		x2 = bp_time[seg+1];
		y1 = bp_value[seg];
		y2 = bp_value[seg+1];
		dx = x2 - x1;
		ans.degenerate = 1'b0;
		if (dx == 0) begin
			ans.degenerate = 1'b1;
			ans.value = '0;
			return ans;
		end
		num  = (x - x1) * (y2 - y1);
		quot = num / dx;
		rem  = num % dx;
		if (quot > INT_LIMIT) offset = OFFSET_LIMIT;
		else if (quot < -INT_LIMIT) offset = -OFFSET_LIMIT;
		else offset = quot * 65536 + (rem * 65536) / dx;
		r = y1 * 65536 + offset;
		// extension past either end stays within half a step of the nearer endpoint
		if (x > x2) begin
			if (y2 > y1) begin
				if (r > y2 * 65536 + HALF_STEP) r = y2 * 65536 + HALF_STEP;
			end else begin
				if (r < y2 * 65536 - HALF_STEP) r = y2 * 65536 - HALF_STEP;
			end
		end else if (x < x1) begin
			if (y1 > y2) begin
				if (r > y1 * 65536 + HALF_STEP) r = y1 * 65536 + HALF_STEP;
			end else begin
				if (r < y1 * 65536 - HALF_STEP) r = y1 * 65536 - HALF_STEP;
			end
		end
		if (r > VALUE_HI) r = VALUE_HI;
		if (r < VALUE_LO) r = VALUE_LO;
		ans.value = bti_pkg::RESULT_W'(r);
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t                             want;
		logic signed [bti_pkg::RESULT_W-1:0] got_value;
		logic [bti_pkg::INDEX_W-1:0]         idx;
		if (!arst_n) begin
			point_count = bti_pkg::COUNT_RESET;
			expected_answers.delete();
			failures = 0;
			pending = 0;
			writes_seen = 0;
			queries_seen = 0;
			degenerate_seen = 0;
			outside_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_value = m_tdata[bti_pkg::RESULT_W-1:0];
				if (expected_answers.size() == 0) begin
					$display("%0t: unexpected result value %0d degenerate %0b", $time,
						got_value, m_tuser);
					failures++;
				end else begin
					want = expected_answers.pop_front();
					if (got_value !== want.value) begin
						$display("%0t: interpolated_value expected %0d got %0d", $time,
							want.value, got_value);
						failures++;
					end
					if (m_tuser !== want.degenerate) begin
						$display("%0t: degenerate expected %0b got %0b", $time,
							want.degenerate, m_tuser);
						failures++;
					end
				end
			end
			if (cfg_we) point_count = cfg_wdata;
			if (s_tvalid && s_tready) begin
				if (bti_pkg::action_t'(s_tuser) == bti_pkg::ACT_WRITE) begin
					idx = s_tdata[bti_pkg::IDX_LO +: bti_pkg::INDEX_W];
					bp_time[idx]  = s_tdata[bti_pkg::ETIME_LO +: bti_pkg::TIME_W];
					bp_value[idx] = s_tdata[bti_pkg::EVAL_LO +: bti_pkg::VALUE_W];
					writes_seen++;
				end else begin
					want = interpolate_at(s_tdata[bti_pkg::QTIME_LO +: bti_pkg::TIME_W]);
					expected_answers.push_back(want);
					queries_seen++;
					if (want.degenerate) degenerate_seen++;
					if (want.outside) outside_seen++;
				end
			end
			pending = expected_answers.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// testbench top for breakpoint_table_interpolator_top: clock, reset, request and result
// stimulus and the verdict; depends on bti_pkg and interpolation_checker
module tb_top;

	localparam int ITEM_TARGET    = 700;
	// wait for a query to finish; used before config writes and at the end
	localparam int QUERY_LATENCY  = 120;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	// point counts of the first phases: full table, below range, above range, small table
	localparam int PRESET_COUNT [6] = '{64, 0, 1, 127, 65, 3};

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [bti_pkg::COUNT_W-1:0]    cfg_wdata = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [bti_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic                           s_tuser = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [bti_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           m_tuser;

	int failures, pending, writes_seen, queries_seen, degenerate_seen, outside_seen;

	// stimulus side bookkeeping
	int                                items_sent = 0;
	int                                settings_used = 0;
	bit                                tx_idle_on = 1'b0;
	bit                                rx_stall_on = 1'b0;
	bit                                long_hold = 1'b0;
	// copy of the table times, only to aim queries at interesting places
	logic signed [bti_pkg::TIME_W-1:0] tbl_time [64];
	int                                tbl_n = 2;
	int                                idle_cycles = 0;

	always #10 clk = ~clk;

	breakpoint_table_interpolator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	interpolation_checker answer_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.failures        (failures),
		.pending         (pending),
		.writes_seen     (writes_seen),
		.queries_seen    (queries_seen),
		.degenerate_seen (degenerate_seen),
		.outside_seen    (outside_seen)
	);

	// watchdog: a stretch with no request, result or config write means the block hung
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, idle_cycles);
			$display("breakpoint_table_interpolator_top verification failed");
			$finish;
		end
	end

	// result side: random stall bursts, and a long hold whenever the stimulus requests one
	always begin
		@(negedge clk);
		if (!arst_n) begin
			m_tready = 1'b0;
		end else if (long_hold) begin
			m_tready = 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
			long_hold = 1'b0;
			m_tready = 1'b1;
		end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
			m_tready = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
			m_tready = 1'b1;
		end else begin
			m_tready = 1'b1;
		end
	end

	function automatic logic signed [bti_pkg::TIME_W-1:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return bti_pkg::TIME_W'(v);
	endfunction

	// one request on the slave side; called and returning at a falling edge
	task automatic send_request(input bti_pkg::action_t act,
			input logic [bti_pkg::INDEX_W-1:0] idx,
			input logic signed [bti_pkg::TIME_W-1:0] etime,
			input logic signed [bti_pkg::VALUE_W-1:0] evalue,
			input logic signed [bti_pkg::TIME_W-1:0] qtime);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_tdata = '0;
		s_tdata[bti_pkg::IDX_LO +: bti_pkg::INDEX_W]  = idx;
		s_tdata[bti_pkg::ETIME_LO +: bti_pkg::TIME_W] = etime;
		s_tdata[bti_pkg::EVAL_LO +: bti_pkg::VALUE_W] = evalue;
		s_tdata[bti_pkg::QTIME_LO +: bti_pkg::TIME_W] = qtime;
		s_tuser  = act;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// unused fields of each request carry random bits so they toggle too
	task automatic write_entry(input int idx, input logic signed [bti_pkg::TIME_W-1:0] t,
			input logic signed [bti_pkg::VALUE_W-1:0] v);
		send_request(bti_pkg::ACT_WRITE, bti_pkg::INDEX_W'(idx), t, v, $urandom());
		if (idx < 64) tbl_time[idx] = t;
	endtask

	task automatic query_at(input logic signed [bti_pkg::TIME_W-1:0] t);
		send_request(bti_pkg::ACT_QUERY, bti_pkg::INDEX_W'($urandom()), $urandom(),
			bti_pkg::VALUE_W'($urandom()), t);
	endtask

	// config writes only with nothing in flight and the block given time to settle
	task automatic set_point_count(input int count);
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (QUERY_LATENCY) @(negedge clk);
		cfg_wdata = bti_pkg::COUNT_W'(count);
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_wdata = bti_pkg::COUNT_W'($urandom());
		settings_used++;
	endtask

	// fill entries 0..n-1: mostly ascending times with random spacing and values,
	// sometimes repeated times, sometimes an unsorted table
	task automatic load_table(input int n);
		int          tmode, vmode;
		int unsigned step_max;
		longint      t, v;
		tmode = $urandom_range(0, 9);
		vmode = $urandom_range(0, 2);
		if (tmode <= 1) begin
			// spread over the whole time axis
			t = -64'sd2147483648 + $urandom_range(0, 65535);
			step_max = 32'hffffffff / n;
		end else begin
			t = longint'($signed($urandom())) >>> $urandom_range(0, 12);
			step_max = 32'd1 << $urandom_range(4, 24);
		end
		v = longint'($signed(bti_pkg::VALUE_W'($urandom())));
		for (int k = 0; k < n; k++) begin
			if (vmode == 0) v = longint'($signed(bti_pkg::VALUE_W'($urandom())));
			else if (vmode == 1) v = v + $urandom_range(0, 128) - 64;
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			if (tmode == 9) write_entry(k, $urandom(), bti_pkg::VALUE_W'(v));
			else write_entry(k, clamp32(t), bti_pkg::VALUE_W'(v));
			if ($urandom_range(0, 15) != 0) t = t + $urandom_range(1, step_max);
		end
	endtask

	function automatic logic signed [bti_pkg::TIME_W-1:0] pick_query_time();
		longint          first, last, width, lo;
		longint unsigned rnd, span;
		first = tbl_time[0];
		last  = tbl_time[tbl_n-1];
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return tbl_time[$urandom_range(0, tbl_n - 1)];
			2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: begin
				// around the table with a margin on both ends for the extension
				width = last - first;
				if (width < 0) width = -width;
				lo = (first < last ? first : last) - width / 4 - 65536;
				span = longint'(width + width / 2 + 131072);
				rnd = {$urandom(), $urandom()};
				return clamp32(lo + longint'(rnd % span));
			end
		endcase
	endfunction

	initial begin
		int count, queries;
		int phase;

		phase = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part at the reset point_count of two
		write_entry(0, 32'sh00010000, 16'sd10);
		write_entry(1, 32'sh00050000, 16'sd30);
		query_at(32'sh00030000);                 // inside a rising segment
		query_at(32'sh00010000);                 // on the first point
		query_at(32'sh00050000);                 // on the last point
		query_at(32'sh00000000);                 // before the table, clamped below v1
		query_at(32'sh00070000);                 // after the table, clamped above v2
		query_at(32'sh00018000);                 // fractional result
		query_at(32'sh80000000);
		query_at(32'sh7fffffff);
		// extreme times and values, falling across the whole axis
		write_entry(0, 32'sh80000000, 16'sh7fff);
		write_entry(1, 32'sh7fffffff, 16'sh8000);
		query_at(32'sh00000000);
		query_at(32'sh80000000);
		query_at(32'sh7fffffff);
		// equal segment times
		write_entry(1, 32'sh80000000, 16'sd0);
		query_at(32'sh00003039);
		// falling segment, queried on both sides
		write_entry(0, 32'sh00010000, -16'sd5);
		write_entry(1, 32'sh00030000, -16'sd9);
		query_at(32'sh00000000);
		query_at(32'sh00050000);
		query_at(32'sh00020000);

		// random phases, each with its own point_count and a freshly loaded table
		while (items_sent < ITEM_TARGET) begin
			phase++;
			if (phase <= 6) count = PRESET_COUNT[phase-1];
			else if ($urandom_range(0, 2) == 0) count = $urandom_range(0, 127);
			else count = $urandom_range(2, 64);
			set_point_count(count);
			tbl_n = count < 2 ? 2 : (count > 64 ? 64 : count);
			// the tail of the run goes without any idling
			if (items_sent >= ITEM_TARGET - 120) begin
				tx_idle_on = 1'b0;
				rx_stall_on = 1'b0;
			end else begin
				tx_idle_on = $urandom_range(0, 3) != 0;
				rx_stall_on = $urandom_range(0, 3) != 0;
			end
			load_table(tbl_n);
			// back up the result side so the input stalls behind a full output register
			if (phase == 3 || phase == 8) long_hold = 1'b1;
			queries = $urandom_range(10, 40);
			repeat (queries) begin
				if ($urandom_range(0, 9) == 0) begin
					write_entry($urandom_range(0, 63), $urandom(),
						bti_pkg::VALUE_W'($urandom()));
				end else begin
					query_at(pick_query_time());
				end
			end
		end

		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (QUERY_LATENCY) @(negedge clk);
		$display("covered %0d table writes and %0d queries over %0d point_count settings",
			writes_seen, queries_seen, settings_used);
		$display("%0d queries fell outside the table, %0d hit equal-time segments",
			outside_seen, degenerate_seen);
		if (failures == 0) begin
			$display("breakpoint_table_interpolator_top verification clean");
		end else begin
			$display("breakpoint_table_interpolator_top verification failed");
		end
		$finish;
	end

endmodule
